@@ src/oaht_pkg.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table package
// Shared codes, result layout and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package oaht_pkg;

    typedef enum logic [1:0] {
        ACT_SET  = 2'd0,
        ACT_GET  = 2'd1,
        ACT_POP  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        RES_INSERTED  = 3'd0,
        RES_REPLACED  = 3'd1,
        RES_FOUND     = 3'd2,
        RES_NOT_FOUND = 3'd3,
        RES_LIMIT     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        TAG_EMPTY = 2'd0,
        TAG_LIVE  = 2'd1,
        TAG_TOMB  = 2'd2
    } tag_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_RESULT
    } state_t;

    localparam logic CFG_TABLE_SIZE_LOG2 = 1'b0;
    localparam logic CFG_MAX_PROBES      = 1'b1;

    localparam int CFG_W      = 11;
    localparam int LOG2_W     = 4;
    localparam int COUNT_W    = 11;
    localparam int RESULT_W   = 32;
    localparam int OUT_USED_W = 3 + RESULT_W + COUNT_W + COUNT_W;
    localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_W - OUT_USED_W;

    localparam logic [LOG2_W-1:0]  TABLE_LOG2_RESET = 4'd3;
    localparam logic [LOG2_W-1:0]  TABLE_LOG2_MIN   = 4'd3;
    localparam logic [COUNT_W-1:0] MAX_PROBES_RESET = 11'd1024;

    typedef struct packed {
        logic clear_wr;
        logic start;
        logic limit;
        logic issue_rd;
        logic check;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic bad_action;
        logic limit_hit;
        logic stop;
        logic out_free;
    } dp_status_t;

endpackage

@@ src/open_addressing_hash_table.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table
// Key/value store with set, get and pop requests over a perturbation probe.
// ----------------------------------------------------------------------------
// After reset the block sweeps its slot memory once to mark every slot empty;
// no item is taken during that pass, while configuration writes are. An item
// then examines at least one slot and at most max_probes (a max_probes of zero
// counting as one): the single-port slot memory gives one registered read
// per slot and the result is checked in the following cycle; a walk cut off
// by the probe limit ends when the limit is seen in the cycle that would
// issue the next read. An item with an unknown action reads no slot and goes
// straight to its result. A finished result sits in an output register, so
// the next item is accepted while that result still waits to be taken; a
// later result that finds it still waiting holds the block until it is taken.
module open_addressing_hash_table import oaht_pkg::*; #(
    parameter int MAX_SLOTS  = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32,
    localparam int IN_W      = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    // Fields from bit 0: action, key, value, zero fill.
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // Fields from bit 0: status, result_value, probes, live_entries, zero fill.
    output logic [OUT_W-1:0] m_tdata
);

    action_t               in_action;
    logic [KEY_BITS-1:0]   in_key;
    logic [VALUE_BITS-1:0] in_value;
    dp_cmd_t               dp_cmd;
    dp_status_t            dp_status;
    status_t               out_status;
    logic [RESULT_W-1:0]   out_value;
    logic [COUNT_W-1:0]    out_probes;
    logic [COUNT_W-1:0]    out_live;

    assign in_action = action_t'(s_tdata[1:0]);
    assign in_key    = s_tdata[2 +: KEY_BITS];
    assign in_value  = s_tdata[2 + KEY_BITS +: VALUE_BITS];

    oaht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    oaht_datapath #(
        .MAX_SLOTS  (MAX_SLOTS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_action  (in_action),
        .in_key     (in_key),
        .in_value   (in_value),
        .dp_cmd     (dp_cmd),
        .dp_status  (dp_status),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_value  (out_value),
        .out_probes (out_probes),
        .out_live   (out_live)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_live, out_probes, out_value, out_status};

endmodule

@@ src/oaht_ctrl.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table controller
// Sequences the clearing pass, item intake, the probe walk and result hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl import oaht_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t dp_status,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (dp_status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = dp_status.bad_action ? ST_RESULT : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = dp_status.limit_hit ? ST_RESULT : ST_CHECK;
            end
            ST_CHECK:
            begin
                state_next = dp_status.stop ? ST_RESULT : ST_PROBE;
            end
            ST_RESULT:
            begin
                if (dp_status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd   = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                dp_cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                dp_cmd.start = in_valid;
            end
            ST_PROBE:
            begin
                dp_cmd.limit    = dp_status.limit_hit;
                dp_cmd.issue_rd = !dp_status.limit_hit;
            end
            ST_CHECK:
            begin
                dp_cmd.check = 1'b1;
            end
            ST_RESULT:
            begin
                dp_cmd.load_out = dp_status.out_free;
            end
            default:
            begin
                dp_cmd = '0;
            end
        endcase
    end

endmodule

@@ src/oaht_datapath.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table datapath
// Slot memory, configuration registers, probe sequence arithmetic, the live
// entry count and the output register.
// ----------------------------------------------------------------------------
module oaht_datapath import oaht_pkg::*; #(
    parameter int MAX_SLOTS  = 1024,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  action_t               in_action,
    input  logic [KEY_BITS-1:0]   in_key,
    input  logic [VALUE_BITS-1:0] in_value,
    input  dp_cmd_t               dp_cmd,
    output dp_status_t            dp_status,
    input  logic                  out_ready,
    output logic                  out_valid,
    output status_t               out_status,
    output logic [RESULT_W-1:0]   out_value,
    output logic [COUNT_W-1:0]    out_probes,
    output logic [COUNT_W-1:0]    out_live
);

    localparam int AW       = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int LOG2_MAX = $clog2(MAX_SLOTS + 1) - 1;
    localparam int LCW      = $clog2(MAX_SLOTS + 1);
    localparam int ROW_W    = 2 + KEY_BITS + VALUE_BITS;

    logic [ROW_W-1:0] mem [MAX_SLOTS];

    logic [LOG2_W-1:0]     tbl_log2_reg;
    logic [COUNT_W-1:0]    max_probes_reg;
    logic [AW-1:0]         clr_addr_reg;
    action_t               action_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [KEY_BITS-1:0]   perturb_reg;
    logic [AW-1:0]         i_reg;
    logic [COUNT_W-1:0]    examined_reg;
    logic [COUNT_W-1:0]    coll_reg;
    logic                  have_tomb_reg;
    logic [AW-1:0]         tomb_reg;
    logic [ROW_W-1:0]      rd_row_reg;
    status_t               res_status_reg;
    logic [VALUE_BITS-1:0] res_value_reg;
    logic [LCW-1:0]        live_count_reg;
    logic                  out_valid_reg;
    status_t               out_status_reg;
    logic [RESULT_W-1:0]   out_value_reg;
    logic [COUNT_W-1:0]    out_probes_reg;
    logic [COUNT_W-1:0]    out_live_reg;

    logic [LOG2_W-1:0]     lg_eff;
    logic [31:0]           mask_w;
    logic [AW-1:0]         mask;
    logic [AW-1:0]         idx;
    logic [COUNT_W-1:0]    limit_eff;
    logic [63:0]           key_in_w;
    logic [63:0]           perturb_w;
    logic [63:0]           res_value_w;
    logic [31:0]           live_w;
    logic [1:0]            rd_tag;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_value;
    logic                  hit_empty;
    logic                  hit_match;
    logic                  stop;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    status_t               chk_status;
    logic [VALUE_BITS-1:0] chk_value;
    logic                  live_inc;
    logic                  live_dec;

    always_comb
    begin
        lg_eff = tbl_log2_reg;
        if (tbl_log2_reg < TABLE_LOG2_MIN)
        begin
            lg_eff = TABLE_LOG2_MIN;
        end
        else if (32'(tbl_log2_reg) > LOG2_MAX)
        begin
            lg_eff = LOG2_W'(LOG2_MAX);
        end
    end

    assign mask_w    = (32'd1 << lg_eff) - 32'd1;
    assign mask      = mask_w[AW-1:0];
    assign idx       = i_reg & mask;
    assign limit_eff = (max_probes_reg == '0) ? COUNT_W'(1) : max_probes_reg;
    assign key_in_w  = 64'(in_key);
    assign perturb_w = 64'(perturb_reg);

    assign rd_tag    = rd_row_reg[ROW_W-1 -: 2];
    assign rd_key    = rd_row_reg[VALUE_BITS +: KEY_BITS];
    assign rd_value  = rd_row_reg[VALUE_BITS-1:0];
    assign hit_empty = (rd_tag == TAG_EMPTY);
    assign hit_match = (rd_tag == TAG_LIVE) && (rd_key == key_reg);
    assign stop      = hit_empty || hit_match;

    always_comb
    begin
        chk_status = RES_NOT_FOUND;
        chk_value  = '0;
        live_inc   = 1'b0;
        live_dec   = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = idx;
        mem_wdata  = {TAG_LIVE, key_reg, value_reg};
        if (dp_cmd.clear_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = {TAG_EMPTY, {(KEY_BITS + VALUE_BITS){1'b0}}};
        end
        else if (dp_cmd.check && stop)
        begin
            unique case (action_reg)
                ACT_SET:
                begin
                    mem_we    = 1'b1;
                    chk_value = value_reg;
                    if (hit_match)
                    begin
                        chk_status = RES_REPLACED;
                    end
                    else
                    begin
                        chk_status = RES_INSERTED;
                        live_inc   = 1'b1;
                        if (have_tomb_reg)
                        begin
                            mem_waddr = tomb_reg;
                        end
                    end
                end
                ACT_GET, ACT_POP:
                begin
                    if (hit_match)
                    begin
                        chk_status = RES_FOUND;
                        chk_value  = rd_value;
                        if (action_reg == ACT_POP)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {TAG_TOMB, rd_key, rd_value};
                            live_dec  = (live_count_reg != '0);
                        end
                    end
                end
                default:
                begin
                    chk_status = RES_NOT_FOUND;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (dp_cmd.issue_rd)
        begin
            rd_row_reg <= mem[idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_log2_reg   <= TABLE_LOG2_RESET;
            max_probes_reg <= MAX_PROBES_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_TABLE_SIZE_LOG2: tbl_log2_reg   <= cfg_wdata[LOG2_W-1:0];
                CFG_MAX_PROBES:      max_probes_reg <= cfg_wdata;
                default:             max_probes_reg <= max_probes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg   <= '0;
            live_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (dp_cmd.clear_wr)
            begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (live_inc)
            begin
                live_count_reg <= live_count_reg + LCW'(1);
            end
            else if (live_dec)
            begin
                live_count_reg <= live_count_reg - LCW'(1);
            end
            if (dp_cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign res_value_w = 64'(res_value_reg);
    assign live_w      = 32'(live_count_reg);

    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            action_reg     <= in_action;
            key_reg        <= in_key;
            value_reg      <= in_value;
            perturb_reg    <= in_key;
            i_reg          <= key_in_w[AW-1:0] & mask;
            examined_reg   <= '0;
            coll_reg       <= '0;
            have_tomb_reg  <= 1'b0;
            res_status_reg <= RES_NOT_FOUND;
            res_value_reg  <= '0;
        end
        if (dp_cmd.limit)
        begin
            res_status_reg <= RES_LIMIT;
            res_value_reg  <= '0;
        end
        if (dp_cmd.issue_rd)
        begin
            examined_reg <= examined_reg + COUNT_W'(1);
        end
        if (dp_cmd.check)
        begin
            if (stop)
            begin
                res_status_reg <= chk_status;
                res_value_reg  <= chk_value;
            end
            else
            begin
                coll_reg    <= coll_reg + COUNT_W'(1);
                i_reg       <= (i_reg << 2) + i_reg + AW'(1) + perturb_w[AW-1:0];
                perturb_reg <= perturb_reg >> 5;
                if (!have_tomb_reg && rd_tag != TAG_LIVE)
                begin
                    have_tomb_reg <= 1'b1;
                    tomb_reg      <= idx;
                end
            end
        end
        if (dp_cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_w[RESULT_W-1:0];
            out_probes_reg <= coll_reg;
            out_live_reg   <= live_w[COUNT_W-1:0];
        end
    end

    assign dp_status.clear_last = (clr_addr_reg == AW'(MAX_SLOTS - 1));
    assign dp_status.bad_action = (in_action == ACT_NONE);
    assign dp_status.limit_hit  = (examined_reg >= limit_eff);
    assign dp_status.stop       = stop;
    assign dp_status.out_free   = !out_valid_reg || out_ready;

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_value  = out_value_reg;
    assign out_probes = out_probes_reg;
    assign out_live   = out_live_reg;

endmodule

@@ src/oaht_checker.sv @@
// ----------------------------------------------------------------------------
// Open-addressing hash table port checker
// Watches the top-level ports for result and reset behavior over time.
// ----------------------------------------------------------------------------
module oaht_port_checker import oaht_pkg::*; (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2:0] <= RES_LIMIT)
        else $error("result status out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] == RES_NOT_FOUND || m_tdata[2:0] == RES_LIMIT)
        |-> m_tdata[34:3] == '0)
        else $error("miss or probe limit carried a nonzero value");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while a request was in progress");

    a_clear_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !s_tready)
        else $error("item taken before the clearing pass");

endmodule

bind open_addressing_hash_table oaht_port_checker u_oaht_port_checker (.*);

@@ verif/oaht_checker.sv @@
// ----------------------------------------------------------------------------
// Hash table reply checker
// Watches the configuration port and both item channels of the hash table.
// It keeps its own copy of the slot store and predicts every reply in request
// order. Each accepted reply is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module oaht_checker import oaht_pkg::*; #(
    parameter int SLOTS = 1024,
    parameter int IN_W  = 72
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               checked,
    output int               limit_stops,
    output int               tomb_reuses,
    output int               longest_walk
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOT_W     = $clog2(SLOTS);
    localparam int DATA_W     = 32;
    localparam int VALUE_LSB  = 3;
    localparam int PROBES_LSB = VALUE_LSB + RESULT_W;
    localparam int LIVE_LSB   = PROBES_LSB + COUNT_W;

    typedef enum {WALK_LIMIT, WALK_EMPTY, WALK_MATCH} walk_end_t;

    typedef struct packed {
        status_t               status;
        logic [RESULT_W-1:0]   value;
        logic [COUNT_W-1:0]    probes;
        logic [COUNT_W-1:0]    live;
    } table_reply_t;

    logic [DATA_W-1:0] slot_keys   [SLOTS];
    logic [DATA_W-1:0] slot_values [SLOTS];
    tag_t              slot_tags   [SLOTS];
    int unsigned       live_total;
    logic [LOG2_W-1:0] size_log2;
    logic [CFG_W-1:0]  probe_cap;
    table_reply_t      awaited_replies [$];

    // Walks the probe sequence for one request and applies its effect.
    function automatic table_reply_t serve_request(input action_t act,
                                                   input logic [DATA_W-1:0] key,
                                                   input logic [DATA_W-1:0] value);
        table_reply_t      reply;
        int unsigned       lg;
        int unsigned       limit;
        int unsigned       looked;
        int unsigned       passed;
        walk_end_t         walk_end;
        logic [63:0]       mask;
        logic [63:0]       walk;
        logic [63:0]       perturb;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] tomb;
        bit                have_tomb;
        reply.status = RES_NOT_FOUND;
        reply.value  = '0;
        lg = size_log2;
        if (lg < TABLE_LOG2_MIN)
            lg = TABLE_LOG2_MIN;
        if (lg > SLOT_W)
            lg = SLOT_W;
        mask = (64'd1 << lg) - 64'd1;
        limit = (probe_cap == 0) ? 1 : probe_cap;
        looked = 0;
        passed = 0;
        walk_end = WALK_LIMIT;
        have_tomb = 1'b0;
        tomb = '0;
        if (act != ACT_NONE)
        begin
            walk = {32'd0, key} & mask;
            perturb = {32'd0, key};
            slot = SLOT_W'(walk);
            while (looked < limit && walk_end == WALK_LIMIT)
            begin
                looked++;
                if (slot_tags[slot] == TAG_EMPTY)
                    walk_end = WALK_EMPTY;
                else if (slot_tags[slot] == TAG_LIVE && slot_keys[slot] == key)
                    walk_end = WALK_MATCH;
                else
                begin
                    if (slot_tags[slot] != TAG_LIVE && !have_tomb)
                    begin
                        have_tomb = 1'b1;
                        tomb = slot;
                    end
                    passed++;
                    walk = walk * 64'd5 + 64'd1 + perturb;
                    perturb = perturb >> 5;
                    slot = SLOT_W'(walk & mask);
                end
            end
            if (walk_end == WALK_LIMIT)
            begin
                reply.status = RES_LIMIT;
                limit_stops++;
            end
            else if (act == ACT_SET)
            begin
                if (walk_end == WALK_MATCH)
                begin
                    slot_values[slot] = value;
                    reply.status = RES_REPLACED;
                end
                else
                begin
                    if (have_tomb)
                    begin
                        slot = tomb;
                        tomb_reuses++;
                    end
                    slot_keys[slot] = key;
                    slot_values[slot] = value;
                    slot_tags[slot] = TAG_LIVE;
                    live_total++;
                    reply.status = RES_INSERTED;
                end
                reply.value = value;
            end
            else if (walk_end == WALK_MATCH)
            begin
                reply.value = slot_values[slot];
                reply.status = RES_FOUND;
                if (act == ACT_POP)
                begin
                    slot_tags[slot] = TAG_TOMB;
                    if (live_total > 0)
                        live_total--;
                end
            end
        end
        reply.probes = COUNT_W'(passed);
        reply.live = COUNT_W'(live_total);
        if (passed > longest_walk)
            longest_walk = passed;
        return reply;
    endfunction

    // Lines past the first forty are counted but not printed.
    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        fail_count++;
        if (fail_count <= 40)
            $display("[%0t] reply %0d: %s is 0x%0h, expected 0x%0h",
                     $realtime, checked, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_reply_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < SLOTS; j++)
            begin
                slot_keys[j] = '0;
                slot_values[j] = '0;
                slot_tags[j] = TAG_EMPTY;
            end
            live_total = 0;
            size_log2 = TABLE_LOG2_RESET;
            probe_cap = MAX_PROBES_RESET;
            awaited_replies.delete();
            fail_count = 0;
            checked = 0;
            limit_stops = 0;
            tomb_reuses = 0;
            longest_walk = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == CFG_TABLE_SIZE_LOG2)
                    size_log2 = cfg_wdata[LOG2_W-1:0];
                else if (cfg_addr == CFG_MAX_PROBES)
                    probe_cap = cfg_wdata;
            end
            if (m_tvalid && m_tready)
            begin
                if (awaited_replies.size() == 0)
                    flag_mismatch("reply with no request waiting", m_tdata[31:0], '0);
                else
                begin
                    want = awaited_replies.pop_front();
                    checked++;
                    if (m_tdata[2:0] != want.status)
                        flag_mismatch("status", m_tdata[2:0], want.status);
                    if (m_tdata[VALUE_LSB +: RESULT_W] != want.value)
                        flag_mismatch("result_value", m_tdata[VALUE_LSB +: RESULT_W],
                                      want.value);
                    if (m_tdata[PROBES_LSB +: COUNT_W] != want.probes)
                        flag_mismatch("probes", m_tdata[PROBES_LSB +: COUNT_W], want.probes);
                    if (m_tdata[LIVE_LSB +: COUNT_W] != want.live)
                        flag_mismatch("live_entries", m_tdata[LIVE_LSB +: COUNT_W],
                                      want.live);
                end
            end
            if (s_tvalid && s_tready)
                awaited_replies.push_back(serve_request(action_t'(s_tdata[1:0]),
                                                        s_tdata[2 +: DATA_W],
                                                        s_tdata[2 + DATA_W +: DATA_W]));
            pending <= awaited_replies.size();
        end
    end

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Hash table testbench top
// Drives set, get, pop and unknown-action requests into the open-addressing
// hash table over a series of table sizes and probe caps, with bursty input
// and stalling output. The checker beside it predicts and compares replies.
// ----------------------------------------------------------------------------
module tb_top import oaht_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W           = ((2 + 32 + 32 + 7) / 8) * 8;
    localparam int RESET_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 64;
    localparam int KEY_POOL       = 64;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic             cfg_addr;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int checked;
    int limit_stops;
    int tomb_reuses;
    int longest_walk;

    int          burst_left;
    int          quiet_cycles;
    bit          hold_req;
    logic [31:0] key_pool [KEY_POOL];

    open_addressing_hash_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    oaht_checker #(.SLOTS(1024), .IN_W(IN_W)) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .limit_stops  (limit_stops),
        .tomb_reuses  (tomb_reuses),
        .longest_walk (longest_walk)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("** open_addressing_hash_table: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int mode;
        int span;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES)
                begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(8, 120);
                for (int c = 0; c < span && !hold_req; c++)
                begin
                    @(posedge clk);
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 3) != 0);
                        2:       m_tready <= ($urandom_range(0, 1) != 0);
                        default: m_tready <= ($urandom_range(0, 9) == 0);
                    endcase
                end
            end
        end
    end

    task automatic send_req(input action_t act, input logic [31:0] key,
                            input logic [31:0] value);
        int gap;
        s_tdata <= {{(IN_W - 66){1'b0}}, value, key, act};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 30);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic cfg_write(input logic addr, input logic [CFG_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [LOG2_W-1:0] size_code,
                             input logic [CFG_W-1:0] cap, input int count,
                             input bit with_hold);
        int          pick;
        action_t     act;
        logic [31:0] key;
        logic [31:0] value;
        drain_replies();
        cfg_write(CFG_TABLE_SIZE_LOG2, CFG_W'(size_code));
        cfg_write(CFG_MAX_PROBES, cap);
        if (with_hold)
        begin
            hold_req = 1'b1;
            burst_left = 80;
        end
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            act = (pick < 45) ? ACT_SET : (pick < 72) ? ACT_GET :
                  (pick < 95) ? ACT_POP : ACT_NONE;
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
                                               : $urandom;
            pick = $urandom_range(0, 9);
            value = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
            send_req(act, key, value);
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= CFG_TABLE_SIZE_LOG2;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        hold_req = 1'b0;
        burst_left = 0;
        for (int j = 0; j < KEY_POOL; j++)
        begin
            case (j % 4)
                0:       key_pool[j] = j;
                1:       key_pool[j] = $urandom;
                2:       key_pool[j] = ($urandom << 10) | 32'h3;
                default: key_pool[j] = $urandom << 3;
            endcase
        end
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Eight-slot window: empty misses, zero and all-ones keys, a chain
        // through slot zero, a tombstone walked past and then reused, and a
        // full table in which every walk for an absent key runs to the probe cap.
        send_req(ACT_GET, 32'd0, 32'd0);
        send_req(ACT_POP, 32'd0, 32'd0);
        send_req(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(ACT_SET, 32'd0, 32'd0);
        send_req(ACT_GET, 32'd0, 32'd0);
        send_req(ACT_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(ACT_SET, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
        send_req(ACT_GET, 32'hFFFF_FFFF, 32'd0);
        send_req(ACT_SET, 32'd8, 32'd1);
        send_req(ACT_SET, 32'd16, 32'd2);
        send_req(ACT_POP, 32'd8, 32'd0);
        send_req(ACT_GET, 32'd16, 32'd0);
        send_req(ACT_SET, 32'd24, 32'd3);
        send_req(ACT_POP, 32'd0, 32'd0);
        send_req(ACT_GET, 32'd0, 32'd0);
        send_req(ACT_NONE, 32'd0, 32'd0);
        send_req(ACT_SET, 32'h100, 32'h1111_1111);
        send_req(ACT_SET, 32'h200, 32'h2222_2222);
        send_req(ACT_SET, 32'h300, 32'h3333_3333);
        send_req(ACT_SET, 32'h400, 32'h4444_4444);
        send_req(ACT_SET, 32'h500, 32'h5555_5555);
        send_req(ACT_SET, 32'h600, 32'h6666_6666);
        send_req(ACT_POP, 32'd24, 32'd0);
        send_req(ACT_SET, 32'h700, 32'h7777_7777);
        send_req(ACT_GET, 32'h800, 32'd0);

        run_phase(4'd4, 11'd1024, 150, 1'b0);
        run_phase(4'd0, 11'd0, 40, 1'b0);
        run_phase(4'd10, 11'd1024, 220, 1'b1);
        run_phase(4'd15, 11'd3, 100, 1'b0);
        run_phase(4'd5, 11'd200, 120, 1'b0);
        run_phase(4'd3, 11'd1, 60, 1'b0);
        run_phase(4'd6, 11'd2047, 40, 1'b0);
        run_phase(4'd8, 11'd1024, 255, 1'b0);

        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d replies: directed corner requests, then eight table settings",
                 checked);
        $display("(8 to 1024 slots, probe caps 0 to 2047); %0d capped walks, %0d %s %0d.",
                 limit_stops, tomb_reuses, "tombstone reuses, longest walk", longest_walk);
        if (fail_count == 0 && pending == 0)
            $display("** open_addressing_hash_table: PASSED **");
        else
            $display("** open_addressing_hash_table: FAILED **");
        $finish;
    end

endmodule
